// ===== rtl/plti_pkg.sv =====
package plti_pkg;

   localparam int MAX_POINTS = 16;
   localparam int PT_IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int CSR_W      = 5;
   localparam int DATA_W     = 16;
   localparam int IDX_W      = 4;
   localparam int WORD_W     = 2 * DATA_W;
   localparam int FRAC_W     = 10;
   localparam int ACC_W      = DATA_W + FRAC_W;
   localparam int DIV_CNT_W  = $clog2(WORD_W);
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   localparam logic [CSR_W-1:0] POINTS_RESET = CSR_W'(16);

   typedef enum logic {
      CMD_WRITE   = 1'b0,
      CMD_CONVERT = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic [IDX_W-1:0]   point_index;
      logic [DATA_W-1:0]  point_reading;
      logic [DATA_W-1:0]  point_value;
      logic [DATA_W-1:0]  sample;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  converted;
      logic               zero_width;
   } rsp_type;

   typedef struct packed {
      cmd_type             op;
      logic [PT_IDX_W-1:0] addr;
      logic [WORD_W-1:0]   point;
      logic [DATA_W-1:0]   sample;
   } job_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_HEAD = 7'b0000010,
      ST_WALK = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_ADJ  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

endpackage

// ===== rtl/plti_ram.sv =====
module plti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [WIDTH-1:0]                wr_data,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/plti_front.sv =====
module plti_front
   import plti_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    job_valid,
   output job_type job,
   input  logic    job_pop
);

   job_type             q_mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   job_type             entry;
   logic                keep;
   logic                push;
   logic                pop;

   // writes beyond the table are dropped here
   always_comb begin
      keep         = (req_data.command == CMD_CONVERT) ||
                     (int'(req_data.point_index) < MAX_POINTS);
      entry.op     = req_data.command;
      entry.addr   = PT_IDX_W'(req_data.point_index);
      entry.point  = {req_data.point_reading, req_data.point_value};
      entry.sample = req_data.sample;
   end

   assign req_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign push      = req_valid && req_ready && keep;
   assign job_valid = (cnt_ff != '0);
   assign pop       = job_pop && job_valid;
   assign job       = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QDEPTH - 1) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QDEPTH - 1) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      priority if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== rtl/plti_div.sv =====
module plti_div
   import plti_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    quo_ff, quo_in;
   logic [WORD_W-1:0]    den_ff, den_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WORD_W:0]      trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WORD_W-1]} - {1'b0, den_ff};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WORD_W]) begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         step_in = step_ff + DIV_CNT_W'(1);
         if (step_ff == DIV_CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/plti_back.sv =====
module plti_back
   import plti_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CSR_W-1:0] points_in_use,
   input  logic             job_valid,
   input  job_type          job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   state_type             state_ff, state_in;
   logic [DATA_W-1:0]     smp_ff, smp_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      p_ff, p_in;
   logic [WORD_W-1:0]     prev_ff, prev_in;
   logic [DATA_W-1:0]     n_rd_ff, n_rd_in;
   logic [DATA_W-1:0]     n_val_ff, n_val_in;
   logic [ACC_W-1:0]      grad_ff, grad_in;
   logic                  sub_ff, sub_in;
   logic                  flag_ff, flag_in;
   logic [ACC_W-1:0]      prod_ff, prod_in;
   logic [DATA_W-1:0]     conv_ff, conv_in;
   logic                  start_ff, start_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  ram_we;
   logic [PT_IDX_W-1:0]   ram_raddr;
   logic [WORD_W-1:0]     ram_rdata;
   logic [DATA_W-1:0]     rd_rd;
   logic [DATA_W-1:0]     rd_val;
   logic                  zw;
   logic [DATA_W-1:0]     diff;
   logic [ACC_W+DATA_W-1:0] prod_full;
   logic [ACC_W-1:0]      base;
   logic [ACC_W-1:0]      acc;
   logic [CNT_W-1:0]      cnt_clamp;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   plti_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (job.addr),
      .wr_data (job.point),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   plti_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign job_pop = (state_ff == ST_IDLE) && job_valid;
   assign ram_we  = job_pop && (job.op == CMD_WRITE);
   assign rd_rd   = ram_rdata[WORD_W-1:DATA_W];
   assign rd_val  = ram_rdata[DATA_W-1:0];
   assign zw      = (rd_rd == prev_ff[WORD_W-1:DATA_W]);

   assign cnt_clamp = (int'(points_in_use) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                         : CNT_W'(points_in_use);

   assign div_req.start    = start_ff;
   assign div_req.dividend = (WORD_W'(n_val_ff) - WORD_W'(prev_ff[DATA_W-1:0])) << FRAC_W;
   assign div_req.divisor  = WORD_W'(n_rd_ff) - WORD_W'(prev_ff[WORD_W-1:DATA_W]);

   always_comb begin
      unique case (state_ff)
         ST_HEAD: ram_raddr = PT_IDX_W'(1);
         ST_WALK: ram_raddr = PT_IDX_W'(p_ff + CNT_W'(1));
         default: ram_raddr = '0;
      endcase
   end

   always_comb begin
      diff      = sub_ff ? (n_rd_ff - smp_ff) : (smp_ff - n_rd_ff);
      prod_full = (ACC_W+DATA_W)'(grad_ff) * (ACC_W+DATA_W)'(diff);
      base      = {n_val_ff, {FRAC_W{1'b0}}};
      acc       = sub_ff ? (base - prod_ff) : (base + prod_ff);
   end

   always_comb begin
      state_in     = state_ff;
      smp_in       = smp_ff;
      cnt_in       = cnt_ff;
      p_in         = p_ff;
      prev_in      = prev_ff;
      n_rd_in      = n_rd_ff;
      n_val_in     = n_val_ff;
      grad_in      = grad_ff;
      sub_in       = sub_ff;
      flag_in      = flag_ff;
      prod_in      = prod_ff;
      conv_in      = conv_ff;
      start_in     = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_pop && (job.op == CMD_CONVERT)) begin
               smp_in   = job.sample;
               cnt_in   = cnt_clamp;
               flag_in  = 1'b0;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            priority if (smp_ff <= rd_rd) begin
               conv_in  = rd_val;
               flag_in  = 1'b0;
               state_in = ST_FIN;
            end else if (cnt_ff <= CNT_W'(1)) begin
               // one point or none: plain sample / 1024
               grad_in  = ACC_W'(1);
               n_rd_in  = '0;
               n_val_in = '0;
               sub_in   = 1'b0;
               state_in = ST_MUL;
            end else begin
               prev_in  = ram_rdata;
               p_in     = CNT_W'(1);
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            priority if (smp_ff == rd_rd) begin
               conv_in  = rd_val;
               state_in = ST_FIN;
            end else if ((smp_ff < rd_rd) || ((p_ff + CNT_W'(1)) == cnt_ff)) begin
               flag_in  = flag_ff | zw;
               n_rd_in  = rd_rd;
               n_val_in = rd_val;
               sub_in   = (smp_ff < rd_rd);
               if (zw) begin
                  grad_in  = '0;
                  state_in = ST_MUL;
               end else begin
                  start_in = 1'b1;
                  state_in = ST_DIV;
               end
            end else begin
               flag_in = flag_ff | zw;
               prev_in = ram_rdata;
               p_in    = p_ff + CNT_W'(1);
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               grad_in  = div_rsp.quotient[ACC_W-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = prod_full[ACC_W-1:0];
            state_in = ST_ADJ;
         end
         ST_ADJ: begin
            conv_in  = acc[ACC_W-1:FRAC_W];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.converted  = conv_ff;
               rsp_in.zero_width = flag_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff   <= smp_in;
      cnt_ff   <= cnt_in;
      p_ff     <= p_in;
      prev_ff  <= prev_in;
      n_rd_ff  <= n_rd_in;
      n_val_ff <= n_val_in;
      grad_ff  <= grad_in;
      sub_ff   <= sub_in;
      flag_ff  <= flag_in;
      prod_ff  <= prod_in;
      conv_ff  <= conv_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FIN))
      else $error("pending response overwritten");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (p_ff < cnt_ff))
      else $error("walk index past point count");

   a_table_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE) && (job.op == CMD_WRITE))
      else $error("table written during a conversion");

endmodule

// ===== rtl/piecewise_linear_table_interp_top.sv =====
// piecewise linear lookup table with 1/1024 gradient resolution
// req channel (valid/ready): command 0 stores point_reading/point_value in
// slot point_index, command 1 converts sample; one rsp per convert, none
// per write. responses come back in request order.
// csr_wr_en/csr_wr_data set points_in_use; write it only while idle.
// requests enter a two-deep queue, so req_ready stays high while the
// converter works or a response waits on rsp_ready, until the queue fills.
// the converter handles one request at a time: a write stores its point,
// a convert ends at the first point or at an exact match at slot k, or
// else interpolates or extrapolates through the serial gradient divider.
// a stalled rsp_ready holds the response in its output register and the
// converter waits in its final state; the queue keeps accepting until full.
// reset empties the queue, drops any pending response and sets
// points_in_use to 16; table contents are undefined until written.
module piecewise_linear_table_interp_top
   import plti_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   logic [CSR_W-1:0] points_ff, points_in;
   logic             job_valid;
   job_type          job;
   logic             job_pop;

   assign points_in = csr_wr_en ? csr_wr_data : points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= POINTS_RESET;
      end else begin
         points_ff <= points_in;
      end
   end

   plti_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   plti_back u_back (
      .clock         (clock),
      .reset         (reset),
      .points_in_use (points_ff),
      .job_valid     (job_valid),
      .job           (job),
      .job_pop       (job_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule
